>>> rtl/trs_pkg.sv
package trs_pkg;

  localparam int CordicSteps = 16;
  localparam int FullTurn = 23040;
  localparam int QuarterTurn = 5760;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam int LatTrig = CordicSteps + 2;

  function automatic logic signed [25:0] atan_entry(input int i);
    case (i)
      0: atan_entry = 26'sd2949120;
      1: atan_entry = 26'sd1740967;
      2: atan_entry = 26'sd919879;
      3: atan_entry = 26'sd466945;
      4: atan_entry = 26'sd234379;
      5: atan_entry = 26'sd117304;
      6: atan_entry = 26'sd58666;
      7: atan_entry = 26'sd29335;
      8: atan_entry = 26'sd14668;
      9: atan_entry = 26'sd7334;
      10: atan_entry = 26'sd3667;
      11: atan_entry = 26'sd1833;
      12: atan_entry = 26'sd917;
      13: atan_entry = 26'sd458;
      14: atan_entry = 26'sd229;
      default: atan_entry = 26'sd115;
    endcase
  endfunction

  typedef struct packed {
    logic signed [17:0] c;
    logic signed [17:0] s;
  } trig_t;

endpackage

>>> rtl/trs_cordic.sv
module trs_cordic import trs_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle,
  output trig_t              res
);

  // stage 0: wrap into one turn, split quadrant / remainder
  logic [1:0]         quad [CordicSteps+1];
  logic signed [33:0] xs [CordicSteps+1];
  logic signed [33:0] ys [CordicSteps+1];
  logic signed [25:0] zs [CordicSteps+1];
  logic [14:0]        wrapped;
  logic [12:0]        rem;
  logic [1:0]         q0;

  always_comb begin
    logic signed [16:0] a;
    a = 17'(angle);
    if (a >= 17'(FullTurn)) a = a - 17'(FullTurn);
    if (a < 0) a = a + 17'(FullTurn);
    if (a < 0) a = a + 17'(FullTurn);
    wrapped = a[14:0];
    if (wrapped >= 15'(3*QuarterTurn)) begin
      q0 = 2'd3; rem = 13'(wrapped - 15'(3*QuarterTurn));
    end else if (wrapped >= 15'(2*QuarterTurn)) begin
      q0 = 2'd2; rem = 13'(wrapped - 15'(2*QuarterTurn));
    end else if (wrapped >= 15'(QuarterTurn)) begin
      q0 = 2'd1; rem = 13'(wrapped - 15'(QuarterTurn));
    end else begin
      q0 = 2'd0; rem = wrapped[12:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad[0] <= q0;
      xs[0] <= CordicGain;
      ys[0] <= '0;
      zs[0] <= $signed({3'b000, rem, 10'b0});
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        quad[i+1] <= quad[i];
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_entry(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_entry(i);
        end
      end
    end
  end

  function automatic logic signed [17:0] to_q16(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd8192) >>> 14;
    if (r > 34'sd65536) r = 34'sd65536;
    if (r < -34'sd65536) r = -34'sd65536;
    return r[17:0];
  endfunction

  always_ff @(posedge clk) begin
    logic signed [17:0] c, s;
    c = to_q16(xs[CordicSteps]);
    s = to_q16(ys[CordicSteps]);
    if (en) begin
      case (quad[CordicSteps])
        2'd0: begin res.c <= c;  res.s <= s;  end
        2'd1: begin res.c <= -s; res.s <= c;  end
        2'd2: begin res.c <= -c; res.s <= -s; end
        default: begin res.c <= s; res.s <= -c; end
      endcase
    end
  end

endmodule

>>> rtl/trs_transform_matrix_builder.sv
// translate / scale / rotate matrix builder, q16.16
// input channel: in_valid / in_stall with move, turn and stretch per axis
// output channel: out_valid / out_stall with the top three matrix rows
//   (bottom row is 0 0 0 1 and not sent); column 3 carries the move fields
// one transfer per cycle while the output is not stalled; stages from input to output:
//   1 stage angle wrap, 16 cordic stages, 1 quadrant map,
//   2 product stages, 1 round, 1 scale multiply, 1 saturate/output
// the whole pipe advances when the output register is empty or taken, so a
//   stall on the output holds every stage and nothing is lost or repeated
// rst (synchronous, active high) clears all valid bits; data regs keep junk
module trs_transform_matrix_builder import trs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] move_x,
  input  logic signed [31:0] move_y,
  input  logic signed [31:0] move_z,
  input  logic signed [15:0] turn_x,
  input  logic signed [15:0] turn_y,
  input  logic signed [15:0] turn_z,
  input  logic signed [31:0] stretch_x,
  input  logic signed [31:0] stretch_y,
  input  logic signed [31:0] stretch_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] row0_col0,
  output logic signed [31:0] row0_col1,
  output logic signed [31:0] row0_col2,
  output logic signed [31:0] row0_col3,
  output logic signed [31:0] row1_col0,
  output logic signed [31:0] row1_col1,
  output logic signed [31:0] row1_col2,
  output logic signed [31:0] row1_col3,
  output logic signed [31:0] row2_col0,
  output logic signed [31:0] row2_col1,
  output logic signed [31:0] row2_col2,
  output logic signed [31:0] row2_col3
);

  localparam int Depth = LatTrig + 5;

  // global advance: whole pipe moves when output is free
  logic adv;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic [Depth-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[Depth-2:0], in_valid};
  end
  assign out_valid = vld[Depth-1];

  // side data (moves, stretches) delayed alongside trig pipe
  logic signed [31:0] mv [3][LatTrig];
  logic signed [31:0] st [3][LatTrig];
  always_ff @(posedge clk) begin
    if (adv) begin
      mv[0][0] <= move_x; mv[1][0] <= move_y; mv[2][0] <= move_z;
      st[0][0] <= stretch_x; st[1][0] <= stretch_y; st[2][0] <= stretch_z;
      for (int k = 1; k < LatTrig; k++) begin
        for (int a = 0; a < 3; a++) begin
          mv[a][k] <= mv[a][k-1];
          st[a][k] <= st[a][k-1];
        end
      end
    end
  end

  trig_t tx, ty, tz;
  trs_cordic u_cx (.clk(clk), .en(adv), .angle(turn_x), .res(tx));
  trs_cordic u_cy (.clk(clk), .en(adv), .angle(turn_y), .res(ty));
  trs_cordic u_cz (.clk(clk), .en(adv), .angle(turn_z), .res(tz));

  // product stage a: two-factor products (q32)
  logic signed [35:0] zy_cc, zy_sc, sy_sx, sy_cx, zx_sc, zx_ss, zx_cc, zx_cs;
  logic signed [35:0] yx_cs, yx_cc;
  logic signed [17:0] cz_a, sz_a, sy_a;
  logic signed [31:0] mv_a [3], st_a [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      zy_cc <= tz.c * ty.c;
      zy_sc <= tz.s * ty.c;
      sy_sx <= ty.s * tx.s;
      sy_cx <= ty.s * tx.c;
      zx_sc <= tz.s * tx.c;
      zx_ss <= tz.s * tx.s;
      zx_cc <= tz.c * tx.c;
      zx_cs <= tz.c * tx.s;
      yx_cs <= ty.c * tx.s;
      yx_cc <= ty.c * tx.c;
      cz_a <= tz.c; sz_a <= tz.s; sy_a <= ty.s;
      for (int a = 0; a < 3; a++) begin
        mv_a[a] <= mv[a][LatTrig-1];
        st_a[a] <= st[a][LatTrig-1];
      end
    end
  end

  // product stage b: three-factor terms and sums in q48
  logic signed [51:0] e [3][3];
  logic signed [31:0] mv_b [3], st_b [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      e[0][0] <= 52'(zy_cc) <<< 16;
      e[0][1] <= -(52'(cz_a) * 52'(sy_sx)) - (52'(zx_sc) <<< 16);
      e[0][2] <= -(52'(cz_a) * 52'(sy_cx)) + (52'(zx_ss) <<< 16);
      e[1][0] <= 52'(zy_sc) <<< 16;
      e[1][1] <= -(52'(sz_a) * 52'(sy_sx)) + (52'(zx_cc) <<< 16);
      e[1][2] <= -(52'(sz_a) * 52'(sy_cx)) - (52'(zx_cs) <<< 16);
      e[2][0] <= 52'(sy_a) <<< 32;
      e[2][1] <= 52'(yx_cs) <<< 16;
      e[2][2] <= 52'(yx_cc) <<< 16;
      mv_b <= mv_a; st_b <= st_a;
    end
  end

  // round to q16
  logic signed [19:0] r [3][3];
  logic signed [31:0] mv_c [3], st_c [3];
  always_ff @(posedge clk) begin
    logic signed [51:0] t;
    if (adv) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          t = (e[i][j] + (52'sd1 <<< 31)) >>> 32;
          r[i][j] <= t[19:0];
        end
      mv_c <= mv_b; st_c <= st_b;
    end
  end

  // scale multiply (32 x 20)
  logic signed [51:0] p [3][3];
  logic signed [31:0] mv_d [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p[i][j] <= 52'(st_c[i]) * 52'(r[i][j]);
      mv_d <= mv_c;
    end
  end

  // round, saturate, output register
  logic signed [31:0] o [3][4];
  always_ff @(posedge clk) begin
    logic signed [51:0] q;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          q = (p[i][j] + 52'sd32768) >>> 16;
          if (q > 52'sd2147483647) o[i][j] <= 32'sh7fffffff;
          else if (q < -52'sd2147483648) o[i][j] <= 32'sh80000000;
          else o[i][j] <= q[31:0];
        end
        o[i][3] <= mv_d[i];
      end
    end
  end

  assign row0_col0 = o[0][0]; assign row0_col1 = o[0][1];
  assign row0_col2 = o[0][2]; assign row0_col3 = o[0][3];
  assign row1_col0 = o[1][0]; assign row1_col1 = o[1][1];
  assign row1_col2 = o[1][2]; assign row1_col3 = o[1][3];
  assign row2_col0 = o[2][0]; assign row2_col1 = o[2][1];
  assign row2_col2 = o[2][2]; assign row2_col3 = o[2][3];

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(row0_col3))
    else $error("output changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  a_pipe: assert property (@(posedge clk) disable iff (rst)
    !out_stall && vld[Depth-2] |=> out_valid)
    else $error("item lost in pipe");
`endif

endmodule
